>>> src/bvll_fd_pkg.sv
package bvll_fd_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned LEN_W  = 16;
   localparam int unsigned ADDR_W = 48;
   localparam int unsigned CSR_IDX_W = 2;

   // Header layout
   localparam logic [LEN_W-1:0] POS_TYPE     = 16'd0;
   localparam logic [LEN_W-1:0] POS_FUNCTION = 16'd1;
   localparam logic [LEN_W-1:0] POS_LEN_HI   = 16'd2;
   localparam logic [LEN_W-1:0] POS_LEN_LO   = 16'd3;
   localparam logic [LEN_W-1:0] HDR_LEN      = 16'd4;
   localparam logic [LEN_W-1:0] FWD_HDR_LEN  = 16'd10;
   localparam logic [LEN_W-1:0] POS_MAX      = 16'hFFFF;

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BVLL_TYPE = 2'd0,
      CSR_FORWARDED = 2'd1,
      CSR_UNICAST   = 2'd2,
      CSR_BROADCAST = 2'd3
   } csr_index_type;

   localparam logic [BYTE_W-1:0] RST_BVLL_TYPE = 8'd129;
   localparam logic [BYTE_W-1:0] RST_FORWARDED = 8'd4;
   localparam logic [BYTE_W-1:0] RST_UNICAST   = 8'd10;
   localparam logic [BYTE_W-1:0] RST_BROADCAST = 8'd11;

endpackage

>>> src/bvll_fd_if.sv
interface bvll_fd_req_if;
   logic                              valid;
   logic                              ready;
   logic [bvll_fd_pkg::BYTE_W-1:0]    rx_byte;
   logic [bvll_fd_pkg::LEN_W-1:0]     datagram_len;
   logic [bvll_fd_pkg::ADDR_W-1:0]    endpoint_source;
   logic                              last_rx_byte;

   modport source (output valid, rx_byte, datagram_len, endpoint_source, last_rx_byte,
                   input ready);
   modport sink (input valid, rx_byte, datagram_len, endpoint_source, last_rx_byte,
                 output ready);
endinterface

interface bvll_fd_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [bvll_fd_pkg::BYTE_W-1:0]    payload_byte;
   logic                              byte_present;
   logic                              frame_end;
   logic                              was_forwarded;
   logic [bvll_fd_pkg::ADDR_W-1:0]    source_address;
   logic [bvll_fd_pkg::LEN_W-1:0]     payload_length;

   modport source (output valid, payload_byte, byte_present, frame_end, was_forwarded,
                   source_address, payload_length,
                   input ready);
   modport sink (input valid, payload_byte, byte_present, frame_end, was_forwarded,
                 source_address, payload_length,
                 output ready);
endinterface

>>> src/bvll_frame_deframer_top.sv
// BVLL receive deframer. Takes one datagram byte per item, checks the 4-byte
// header (type code, function code, 16-bit length equal to datagram_len) and
// passes payload bytes upward with the source address: the endpoint source for
// original unicast/broadcast frames, the 6-byte header address for forwarded
// frames (at least 10 bytes). Bad, short or unknown frames are dropped without
// a result; an empty payload gives one end-of-frame item with byte_present 0.
// The header checks and the position counter sit between the frame state
// registers and a single output register; a new byte is taken whenever that
// output register is empty or being drained. The user must set codes through
// csr_* only while idle; the block itself does not enforce this.
module bvll_frame_deframer_top (
   input  logic                                 clock,
   input  logic                                 reset,
   bvll_fd_req_if.sink                          req_ch,
   bvll_fd_rsp_if.source                        rsp_ch,
   input  logic                                 csr_we,
   input  logic [bvll_fd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bvll_fd_pkg::BYTE_W-1:0]       csr_wdata
);

   logic [bvll_fd_pkg::BYTE_W-1:0] type_code_ff;
   logic [bvll_fd_pkg::BYTE_W-1:0] fwd_code_ff;
   logic [bvll_fd_pkg::BYTE_W-1:0] uni_code_ff;
   logic [bvll_fd_pkg::BYTE_W-1:0] bc_code_ff;

   logic [bvll_fd_pkg::LEN_W-1:0]  pos_ff, pos_in;
   logic [bvll_fd_pkg::BYTE_W-1:0] func_ff, func_in;
   logic [bvll_fd_pkg::BYTE_W-1:0] len_hi_ff, len_hi_in;
   logic                           drop_ff, drop_in;
   logic                           fwd_ff, fwd_in;
   logic [bvll_fd_pkg::ADDR_W-1:0] hsrc_ff, hsrc_in;

   logic                           out_valid_ff;
   logic [bvll_fd_pkg::BYTE_W-1:0] out_byte_ff, out_byte_in;
   logic                           out_present_ff;
   logic                           out_end_ff, out_end_in;
   logic                           out_fwd_ff;
   logic [bvll_fd_pkg::ADDR_W-1:0] out_src_ff, out_src_in;
   logic [bvll_fd_pkg::LEN_W-1:0]  out_len_ff, out_len_in;

   logic                           accept;
   logic                           emit;
   logic                           present;
   logic [bvll_fd_pkg::LEN_W-1:0]  hdr_len;
   logic [bvll_fd_pkg::BYTE_W-1:0] b;
   logic [bvll_fd_pkg::LEN_W-1:0]  dlen;

   assign req_ch.ready = !out_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;
   assign b            = req_ch.rx_byte;
   assign dlen         = req_ch.datagram_len;
   assign hdr_len      = {len_hi_ff, b};

   always_comb begin
      pos_in    = pos_ff;
      func_in   = func_ff;
      len_hi_in = len_hi_ff;
      drop_in   = drop_ff;
      fwd_in    = fwd_ff;
      hsrc_in   = hsrc_ff;
      emit      = 1'b0;
      present   = 1'b0;

      if (!drop_ff) begin
         if (pos_ff == bvll_fd_pkg::POS_TYPE) begin
            if (b != type_code_ff) drop_in = 1'b1;
         end else if (pos_ff == bvll_fd_pkg::POS_FUNCTION) begin
            func_in = b;
         end else if (pos_ff == bvll_fd_pkg::POS_LEN_HI) begin
            len_hi_in = b;
         end else if (pos_ff == bvll_fd_pkg::POS_LEN_LO) begin
            if (hdr_len != dlen || dlen < bvll_fd_pkg::HDR_LEN) begin
               drop_in = 1'b1;
            end else if (func_ff == fwd_code_ff) begin
               // forwarded wins over a colliding original code
               if (hdr_len < bvll_fd_pkg::FWD_HDR_LEN) drop_in = 1'b1;
               else fwd_in = 1'b1;
            end else if (func_ff == uni_code_ff || func_ff == bc_code_ff) begin
               if (hdr_len == bvll_fd_pkg::HDR_LEN) emit = 1'b1;
            end else begin
               drop_in = 1'b1;
            end
         end else if (fwd_ff && pos_ff < bvll_fd_pkg::FWD_HDR_LEN) begin
            hsrc_in = {hsrc_ff[bvll_fd_pkg::ADDR_W-bvll_fd_pkg::BYTE_W-1:0], b};
            if (pos_ff == bvll_fd_pkg::FWD_HDR_LEN - 16'd1 &&
                dlen == bvll_fd_pkg::FWD_HDR_LEN) emit = 1'b1;
         end else if (pos_ff < dlen) begin
            emit    = 1'b1;
            present = 1'b1;
         end else begin
            drop_in = 1'b1;  // excess bytes beyond datagram_len
         end
      end

      out_end_in  = req_ch.last_rx_byte || !present ||
                    ({1'b0, pos_ff} + 17'd1 == {1'b0, dlen});
      out_byte_in = present ? b : '0;
      out_src_in  = fwd_ff ? hsrc_in : req_ch.endpoint_source;
      out_len_in  = dlen - (fwd_ff ? bvll_fd_pkg::FWD_HDR_LEN : bvll_fd_pkg::HDR_LEN);

      if (emit && out_end_in) drop_in = 1'b1;

      if (req_ch.last_rx_byte) begin
         pos_in  = '0;
         drop_in = 1'b0;
         fwd_in  = 1'b0;
      end else if (pos_ff != bvll_fd_pkg::POS_MAX) begin
         pos_in = pos_ff + 16'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         type_code_ff <= bvll_fd_pkg::RST_BVLL_TYPE;
         fwd_code_ff  <= bvll_fd_pkg::RST_FORWARDED;
         uni_code_ff  <= bvll_fd_pkg::RST_UNICAST;
         bc_code_ff   <= bvll_fd_pkg::RST_BROADCAST;
      end else if (csr_we) begin
         case (csr_index)
            bvll_fd_pkg::CSR_BVLL_TYPE: type_code_ff <= csr_wdata;
            bvll_fd_pkg::CSR_FORWARDED: fwd_code_ff  <= csr_wdata;
            bvll_fd_pkg::CSR_UNICAST:   uni_code_ff  <= csr_wdata;
            bvll_fd_pkg::CSR_BROADCAST: bc_code_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         func_ff   <= '0;
         len_hi_ff <= '0;
         drop_ff   <= 1'b0;
         fwd_ff    <= 1'b0;
         hsrc_ff   <= '0;
      end else if (accept) begin
         pos_ff    <= pos_in;
         func_ff   <= func_in;
         len_hi_ff <= len_hi_in;
         drop_ff   <= drop_in;
         fwd_ff    <= fwd_in;
         hsrc_ff   <= hsrc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         out_valid_ff <= accept && emit;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         out_byte_ff    <= out_byte_in;
         out_present_ff <= present;
         out_end_ff     <= out_end_in;
         out_fwd_ff     <= fwd_ff;
         out_src_ff     <= out_src_in;
         out_len_ff     <= out_len_in;
      end
   end

   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.payload_byte   = out_byte_ff;
   assign rsp_ch.byte_present   = out_present_ff;
   assign rsp_ch.frame_end      = out_end_ff;
   assign rsp_ch.was_forwarded  = out_fwd_ff;
   assign rsp_ch.source_address = out_src_ff;
   assign rsp_ch.payload_length = out_len_ff;

endmodule

>>> verif/bvll_fd_scoreboard_pkg.sv
package bvll_fd_scoreboard_pkg;

   import bvll_fd_pkg::*;

   typedef struct packed {
      logic [BYTE_W-1:0] rx_byte;
      logic [LEN_W-1:0]  datagram_len;
      logic [ADDR_W-1:0] endpoint_source;
      logic              last_rx_byte;
   } rx_item_type;

   typedef struct packed {
      logic [BYTE_W-1:0] payload_byte;
      logic              byte_present;
      logic              frame_end;
      logic              was_forwarded;
      logic [ADDR_W-1:0] source_address;
      logic [LEN_W-1:0]  payload_length;
   } payload_item_type;

   class deframe_scoreboard;
      logic [BYTE_W-1:0] type_code;
      logic [BYTE_W-1:0] fwd_code;
      logic [BYTE_W-1:0] uni_code;
      logic [BYTE_W-1:0] bcast_code;

      logic [LEN_W-1:0]  rx_pos;
      logic [BYTE_W-1:0] fn_byte;
      logic [BYTE_W-1:0] len_hi;
      bit                discarding;
      bit                fwd_frame;
      logic [ADDR_W-1:0] fwd_source;

      payload_item_type  expected_payload_q[$];
      int unsigned       mismatches;
      int unsigned       checked;

      function new();
         type_code  = RST_BVLL_TYPE;
         fwd_code   = RST_FORWARDED;
         uni_code   = RST_UNICAST;
         bcast_code = RST_BROADCAST;
         rx_pos     = '0;
         fn_byte    = '0;
         len_hi     = '0;
         discarding = 1'b0;
         fwd_frame  = 1'b0;
         fwd_source = '0;
         mismatches = 0;
         checked    = 0;
      endfunction

      function void set_code(csr_index_type idx, logic [BYTE_W-1:0] value);
         case (idx)
            CSR_BVLL_TYPE: type_code  = value;
            CSR_FORWARDED: fwd_code   = value;
            CSR_UNICAST:   uni_code   = value;
            CSR_BROADCAST: bcast_code = value;
            default: ;
         endcase
      endfunction

      // Advances the frame state by one accepted byte and queues the payload
      // item it yields, if any.
      function void note_rx_byte(rx_item_type it);
         int unsigned      p;
         int unsigned      dlen;
         int unsigned      hlen;
         bit               emit;
         bit               present;
         bit               ends;
         payload_item_type e;
         p       = rx_pos;
         dlen    = it.datagram_len;
         emit    = 1'b0;
         present = 1'b0;
         if (!discarding) begin
            if (p == POS_TYPE) begin
               if (it.rx_byte != type_code) discarding = 1'b1;
            end else if (p == POS_FUNCTION) begin
               fn_byte = it.rx_byte;
            end else if (p == POS_LEN_HI) begin
               len_hi = it.rx_byte;
            end else if (p == POS_LEN_LO) begin
               hlen = {len_hi, it.rx_byte};
               if (hlen != dlen || dlen < HDR_LEN) begin
                  discarding = 1'b1;
               end else if (fn_byte == fwd_code) begin
                  // forwarded wins when codes collide
                  if (hlen < FWD_HDR_LEN) discarding = 1'b1;
                  else fwd_frame = 1'b1;
               end else if (fn_byte == uni_code || fn_byte == bcast_code) begin
                  if (hlen == HDR_LEN) emit = 1'b1;
               end else begin
                  discarding = 1'b1;
               end
            end else if (fwd_frame && p < FWD_HDR_LEN) begin
               fwd_source = {fwd_source[ADDR_W-BYTE_W-1:0], it.rx_byte};
               if (p == FWD_HDR_LEN - 1 && dlen == FWD_HDR_LEN) emit = 1'b1;
            end else if (p < dlen) begin
               emit    = 1'b1;
               present = 1'b1;
            end else begin
               discarding = 1'b1;
            end
         end

         if (emit) begin
            ends = it.last_rx_byte || !present || (p + 1 == dlen);
            e.payload_byte   = present ? it.rx_byte : '0;
            e.byte_present   = present;
            e.frame_end      = ends;
            e.was_forwarded  = fwd_frame;
            e.source_address = fwd_frame ? fwd_source : it.endpoint_source;
            e.payload_length = it.datagram_len - (fwd_frame ? FWD_HDR_LEN : HDR_LEN);
            expected_payload_q.push_back(e);
            if (ends) discarding = 1'b1;
         end

         if (it.last_rx_byte) begin
            rx_pos     = '0;
            discarding = 1'b0;
            fwd_frame  = 1'b0;
         end else if (rx_pos != POS_MAX) begin
            rx_pos = rx_pos + 1'b1;
         end
      endfunction

      function bit field_ok(string name, logic [ADDR_W-1:0] exp, logic [ADDR_W-1:0] act);
         if (exp !== act) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp, act);
            return 1'b0;
         end
         return 1'b1;
      endfunction

      function void check_payload(payload_item_type got);
         payload_item_type e;
         bit               ok;
         checked++;
         if (expected_payload_q.size() == 0) begin
            $display("%0t: unexpected item, actual byte %0h present %0b end %0b src %0h",
                     $time, got.payload_byte, got.byte_present, got.frame_end,
                     got.source_address);
            mismatches++;
            return;
         end
         e  = expected_payload_q.pop_front();
         ok = field_ok("payload_byte", e.payload_byte, got.payload_byte);
         ok = field_ok("byte_present", e.byte_present, got.byte_present) && ok;
         ok = field_ok("frame_end", e.frame_end, got.frame_end) && ok;
         ok = field_ok("was_forwarded", e.was_forwarded, got.was_forwarded) && ok;
         ok = field_ok("source_address", e.source_address, got.source_address) && ok;
         ok = field_ok("payload_length", e.payload_length, got.payload_length) && ok;
         if (!ok) mismatches++;
      endfunction
   endclass

endpackage

>>> verif/bvll_frame_deframer_top_test.sv
module bvll_frame_deframer_top_test;

   import bvll_fd_pkg::*;
   import bvll_fd_scoreboard_pkg::*;

   localparam int unsigned STALL_LIMIT = 2000;
   localparam int unsigned PHASE_ITEMS = 270;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [BYTE_W-1:0]    csr_wdata;

   bvll_fd_req_if req_ch();
   bvll_fd_rsp_if rsp_ch();

   bvll_frame_deframer_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   deframe_scoreboard sb;
   rx_item_type       rx_seen;
   payload_item_type  payload_seen;
   logic [BYTE_W-1:0] frame_buf[$];
   bit                quiet;
   int unsigned       bytes_sent;
   int unsigned       frame_bytes;
   int unsigned       frames_sent;
   int unsigned       code_sets;
   int unsigned       idle_cycles;

   always #2 clock = ~clock;

   // result first: a result at this edge belongs to an earlier byte
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            payload_seen.payload_byte   = rsp_ch.payload_byte;
            payload_seen.byte_present   = rsp_ch.byte_present;
            payload_seen.frame_end      = rsp_ch.frame_end;
            payload_seen.was_forwarded  = rsp_ch.was_forwarded;
            payload_seen.source_address = rsp_ch.source_address;
            payload_seen.payload_length = rsp_ch.payload_length;
            sb.check_payload(payload_seen);
         end
         if (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) begin
            rx_seen.rx_byte         = req_ch.rx_byte;
            rx_seen.datagram_len    = req_ch.datagram_len;
            rx_seen.endpoint_source = req_ch.endpoint_source;
            rx_seen.last_rx_byte    = req_ch.last_rx_byte;
            sb.note_rx_byte(rx_seen);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
          (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // result side back-pressure
   initial begin
      int unsigned stall;
      forever begin
         stall = quiet ? 0 : $urandom_range(0, 10);
         if (stall != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (rsp_ch.valid !== 1'b1) @(posedge clock);
      end
   end

   task automatic send_byte(input logic [BYTE_W-1:0] b, input logic [LEN_W-1:0] dlen,
                            input logic [ADDR_W-1:0] src, input bit last);
      int unsigned gap;
      gap = quiet ? 0 : $urandom_range(0, 10);
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid           <= 1'b1;
      req_ch.rx_byte         <= b;
      req_ch.datagram_len    <= dlen;
      req_ch.endpoint_source <= src;
      req_ch.last_rx_byte    <= last;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_frame(input logic [LEN_W-1:0] dlen, input logic [ADDR_W-1:0] src);
      foreach (frame_buf[i]) send_byte(frame_buf[i], dlen, src, i == frame_buf.size() - 1);
      frame_bytes += frame_buf.size();
      frames_sent++;
   endtask

   task automatic write_code(input csr_index_type idx, input logic [BYTE_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      sb.set_code(idx, value);
   endtask

   task automatic set_codes(input logic [BYTE_W-1:0] t, input logic [BYTE_W-1:0] f,
                            input logic [BYTE_W-1:0] u, input logic [BYTE_W-1:0] b);
      write_code(CSR_BVLL_TYPE, t);
      write_code(CSR_FORWARDED, f);
      write_code(CSR_UNICAST, u);
      write_code(CSR_BROADCAST, b);
      csr_we <= 1'b0;
      code_sets++;
   endtask

   // drain: dropped bytes give no result, so keep clocking past the last expected one
   task automatic settle();
      req_ch.valid <= 1'b0;
      while (sb.expected_payload_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic send_directed();
      // unicast, empty payload
      frame_buf = '{RST_BVLL_TYPE, RST_UNICAST, 8'h00, 8'h04};
      send_frame(16'd4, '0);
      // forwarded, empty payload, all-ones header address
      frame_buf = '{RST_BVLL_TYPE, RST_FORWARDED, 8'h00, 8'h0A,
                    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
      send_frame(16'd10, '0);
      // broadcast cut short inside the payload
      frame_buf = '{RST_BVLL_TYPE, RST_BROADCAST, 8'h00, 8'h07, 8'h00, 8'hFF};
      send_frame(16'd7, '1);
      // datagram shorter than a header
      frame_buf = '{RST_BVLL_TYPE, RST_UNICAST, 8'h00, 8'h03};
      send_frame(16'd3, 48'h0123_4567_89AB);
      // last mark inside the header
      frame_buf = '{RST_BVLL_TYPE, RST_FORWARDED};
      send_frame(16'd12, 48'hFEDC_BA98_7654);
      // bytes past the datagram length
      frame_buf = '{RST_BVLL_TYPE, RST_UNICAST, 8'h00, 8'h05, 8'h7E, 8'h01};
      send_frame(16'd5, 48'h8000_0000_0001);
   endtask

   task automatic send_random_frame();
      logic [BYTE_W-1:0] tc;
      logic [BYTE_W-1:0] fn;
      logic [LEN_W-1:0]  hlen;
      logic [LEN_W-1:0]  dlen;
      logic [ADDR_W-1:0] src;
      int unsigned       plen;
      int unsigned       nbytes;
      tc = sb.type_code;
      case ($urandom_range(0, 2))
         0: fn = sb.fwd_code;
         1: fn = sb.uni_code;
         default: fn = sb.bcast_code;
      endcase
      plen = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
      hlen = 16'(plen) + ((fn == sb.fwd_code) ? FWD_HDR_LEN : HDR_LEN);
      dlen = hlen;
      nbytes = hlen;
      // most frames are well formed, the rest broken one way or another
      case ($urandom_range(0, 19))
         12: tc = tc ^ 8'($urandom_range(1, 255));
         13: fn = 8'($urandom);
         14: dlen = 16'($urandom);
         15: begin
            hlen = 16'($urandom_range(0, 3));
            dlen = hlen;
            nbytes = $urandom_range(1, 6);
         end
         16: begin
            fn = sb.fwd_code;
            hlen = 16'($urandom_range(4, 9));
            dlen = hlen;
            nbytes = hlen;
         end
         17: nbytes = $urandom_range(1, hlen - 1);
         18: nbytes = hlen + $urandom_range(1, 4);
         19: begin
            hlen = 16'($urandom);
            dlen = hlen;
            nbytes = $urandom_range(1, 16);
         end
         default: ;
      endcase
      frame_buf.delete();
      for (int i = 0; i < nbytes; i++) begin
         case (i)
            0: frame_buf.push_back(tc);
            1: frame_buf.push_back(fn);
            2: frame_buf.push_back(hlen[15:8]);
            3: frame_buf.push_back(hlen[7:0]);
            default: frame_buf.push_back(8'($urandom));
         endcase
      end
      src[47:32] = 16'($urandom);
      src[31:0]  = $urandom;
      quiet = ($urandom_range(0, 7) == 0);
      send_frame(dlen, src);
   endtask

   task automatic run_random(input int unsigned target);
      int unsigned start;
      int unsigned n;
      start = frame_bytes;
      while (frame_bytes - start < target) begin
         if ($urandom_range(0, 9) == 0) begin
            n = $urandom_range(1, 3);
            for (int k = 0; k < n; k++)
               send_byte(8'($urandom), 16'($urandom), {16'($urandom), $urandom}, k == n - 1);
         end else begin
            send_random_frame();
         end
      end
      quiet = 1'b0;
   endtask

   initial begin
      logic [BYTE_W-1:0] shared;
      sb          = new();
      quiet       = 1'b0;
      bytes_sent  = 0;
      frame_bytes = 0;
      frames_sent = 0;
      code_sets   = 0;
      reset                  <= 1'b1;
      csr_we                 <= 1'b0;
      csr_index              <= CSR_BVLL_TYPE;
      csr_wdata              <= '0;
      req_ch.valid           <= 1'b0;
      req_ch.rx_byte         <= '0;
      req_ch.datagram_len    <= '0;
      req_ch.endpoint_source <= '0;
      req_ch.last_rx_byte    <= 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_directed();
      run_random(PHASE_ITEMS);

      settle();
      set_codes(8'h00, 8'hFF, 8'h00, 8'hFF);
      run_random(PHASE_ITEMS);

      settle();
      set_codes(8'hFF, 8'h00, 8'hFF, 8'h00);
      run_random(PHASE_ITEMS);

      // forwarded and unicast share a code
      settle();
      shared = 8'($urandom);
      set_codes(8'($urandom), shared, shared, 8'($urandom));
      run_random(PHASE_ITEMS);

      settle();
      set_codes(RST_BVLL_TYPE, RST_FORWARDED, RST_UNICAST, RST_BROADCAST);
      run_random(PHASE_ITEMS);

      settle();
      $display("Sent %0d frames (%0d bytes) over %0d code settings after reset defaults;",
               frames_sent, bytes_sent, code_sets);
      $display("checked %0d payload items from good, broken and code-colliding frames.",
               sb.checked);
      if (sb.mismatches == 0 && sb.expected_payload_q.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("%0d bad items, %0d expected items never arrived",
                  sb.mismatches, sb.expected_payload_q.size());
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

>>> bvll_frame_deframer_top.f
src/bvll_fd_pkg.sv
src/bvll_fd_if.sv
src/bvll_frame_deframer_top.sv
verif/bvll_fd_scoreboard_pkg.sv
verif/bvll_frame_deframer_top_test.sv
